### rtl/u2l_pkg.sv
// ----------------------------------------------------------------------------
// u2l_pkg : shared types and constants
// Command and status structs between the controller and the datapath, plus the
// UTF-8 lead byte masks and the fixed character codes.
// ----------------------------------------------------------------------------
`default_nettype none

package u2l_pkg;

  localparam logic [7:0] SubstChar   = 8'h3F;
  localparam logic [7:0] LineFeed    = 8'h0A;
  localparam logic [7:0] CarriageRet = 8'h0D;

  localparam logic [7:0] Lead2Mask = 8'hE0;
  localparam logic [7:0] Lead2Pat  = 8'hC0;
  localparam logic [7:0] Lead3Mask = 8'hF0;
  localparam logic [7:0] Lead3Pat  = 8'hE0;
  localparam logic [7:0] Lead4Mask = 8'hF8;
  localparam logic [7:0] Lead4Pat  = 8'hF0;
  localparam logic [7:0] ContMask  = 8'hC0;
  localparam logic [7:0] ContPat   = 8'h80;

  localparam int unsigned HeldDepth  = 4;
  localparam int unsigned MaxResults = 4;

  typedef struct packed {
    logic load;     // append the accepted byte to the held bytes
    logic advance;  // apply one decode pass to the head of the held bytes
    logic trunc;    // substitute a sequence cut off at end of text
    logic finish;   // release the last result of this request
  } u2l_cmd_t;

  typedef struct packed {
    logic done;        // decode loop has nothing more to do
    logic emit;        // the next decode pass produces a character
    logic cap_ok;      // room for another result in this request
    logic blocked;     // a pending character cannot move to the output yet
    logic out_free;    // output register can take a result this cycle
    logic fin;         // current request carries the final byte
    logic held_any;    // bytes still held
    logic pend_valid;  // a character waits for its run_end flag
  } u2l_stat_t;

endpackage

`default_nettype wire

### rtl/u2l_datapath.sv
// ----------------------------------------------------------------------------
// u2l_datapath : held bytes, decoder and result registers
// Holds the partial UTF-8 sequence, decodes its head one pass per command,
// and stages each character until it is known whether it ends the request.
// ----------------------------------------------------------------------------
`default_nettype none

module u2l_datapath (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire u2l_pkg::u2l_cmd_t  cmd_i,
  output u2l_pkg::u2l_stat_t      stat_o,
  input  wire [7:0]           text_byte_i,
  input  wire                 final_byte_i,
  output logic                out_valid_o,
  input  wire                 out_ready_i,
  output logic [7:0]          latin_char_o,
  output logic                char_present_o,
  output logic                run_end_o,
  output logic                text_end_o
);
  import u2l_pkg::*;

  localparam logic [2:0] CntMax = 3'(HeldDepth - 1);
  localparam logic [2:0] ResMax = 3'(MaxResults);

  logic [7:0] held_q [HeldDepth];
  logic [7:0] held_d [HeldDepth];
  logic [2:0] cnt_q, cnt_d;
  logic       drop_q, drop_d;
  logic       fin_q, fin_d;
  logic [2:0] nres_q, nres_d;
  logic       pend_valid_q, pend_valid_d;
  logic [7:0] pend_char_q, pend_char_d;
  logic       out_valid_q, out_valid_d;
  logic [7:0] out_char_q, out_char_d;
  logic       out_present_q, out_present_d;
  logic       out_run_end_q, out_run_end_d;
  logic       out_text_end_q, out_text_end_d;

  logic [7:0] c, b1, b2, b3;
  logic       is1, is2, is3, is4, bad_lead, incomplete, broken;
  logic [2:0] len;
  logic       fits_byte;
  logic [7:0] byte_val;
  logic       it_emit, it_set_drop, it_clr_drop;
  logic [7:0] it_char;
  logic [2:0] it_consume;
  logic       out_free, cap_ok, produce;
  logic [7:0] prod_char;
  logic [2:0] cnt_eff;
  logic [2:0] src_idx;

  assign c  = held_q[0];
  assign b1 = held_q[1];
  assign b2 = held_q[2];
  assign b3 = held_q[3];

  assign is1 = ~c[7];
  assign is2 = (c & Lead2Mask) == Lead2Pat;
  assign is3 = (c & Lead3Mask) == Lead3Pat;
  assign is4 = (c & Lead4Mask) == Lead4Pat;
  assign bad_lead = ~(is1 | is2 | is3 | is4);

  always_comb begin
    len       = 3'd4;
    fits_byte = 1'b0;
    byte_val  = {b2[1:0], b3[5:0]};
    if (is1) begin
      len       = 3'd1;
      fits_byte = 1'b1;
      byte_val  = c;
    end else if (is2) begin
      len       = 3'd2;
      fits_byte = (c[4:2] == 3'd0);
      byte_val  = {c[1:0], b1[5:0]};
    end else if (is3) begin
      len       = 3'd3;
      fits_byte = (c[3:0] == 4'd0) && (b1[5:2] == 4'd0);
      byte_val  = {b1[1:0], b2[5:0]};
    end else begin
      fits_byte = (c[2:0] == 3'd0) && (b1[5:0] == 6'd0) && (b2[5:2] == 4'd0);
    end
  end

  assign incomplete = cnt_q < len;
  assign broken = ((len >= 3'd2) && ((b1 & ContMask) != ContPat)) ||
                  ((len >= 3'd3) && ((b2 & ContMask) != ContPat)) ||
                  ((len == 3'd4) && ((b3 & ContMask) != ContPat));

  always_comb begin
    it_emit     = 1'b0;
    it_char     = SubstChar;
    it_consume  = 3'd0;
    it_set_drop = 1'b0;
    it_clr_drop = 1'b0;
    if (drop_q) begin
      it_clr_drop = 1'b1;
      if (c == LineFeed) begin
        it_consume = 3'd1;
      end
    end else if (bad_lead) begin
      it_emit    = 1'b1;
      it_consume = 3'd1;
    end else if (incomplete) begin
      it_consume = 3'd0;
    end else if (broken) begin
      it_emit    = 1'b1;
      it_consume = 3'd1;
    end else begin
      it_emit    = 1'b1;
      it_consume = len;
      if (fits_byte && byte_val == CarriageRet) begin
        it_char     = LineFeed;
        it_set_drop = 1'b1;
      end else if (fits_byte) begin
        it_char = byte_val;
      end
    end
  end

  assign out_free = ~out_valid_q | out_ready_i;
  assign cap_ok   = nres_q < ResMax;

  assign stat_o.done       = (cnt_q == 3'd0) || (~drop_q & ~bad_lead & incomplete);
  assign stat_o.emit       = it_emit;
  assign stat_o.cap_ok     = cap_ok;
  assign stat_o.blocked    = pend_valid_q & ~out_free;
  assign stat_o.out_free   = out_free;
  assign stat_o.fin        = fin_q;
  assign stat_o.held_any   = cnt_q != 3'd0;
  assign stat_o.pend_valid = pend_valid_q;

  assign produce   = (cmd_i.advance & it_emit & cap_ok) | (cmd_i.trunc & cap_ok);
  assign prod_char = cmd_i.trunc ? SubstChar : it_char;
  assign cnt_eff   = (cnt_q > CntMax) ? CntMax : cnt_q;

  always_comb begin
    held_d         = held_q;
    cnt_d          = cnt_q;
    drop_d         = drop_q;
    fin_d          = fin_q;
    nres_d         = nres_q;
    pend_valid_d   = pend_valid_q;
    pend_char_d    = pend_char_q;
    out_valid_d    = out_valid_q & ~out_ready_i;
    out_char_d     = out_char_q;
    out_present_d  = out_present_q;
    out_run_end_d  = out_run_end_q;
    out_text_end_d = out_text_end_q;
    src_idx        = 3'd0;

    if (cmd_i.load) begin
      held_d[cnt_eff[1:0]] = text_byte_i;
      cnt_d        = cnt_eff + 3'd1;
      fin_d        = final_byte_i;
      nres_d       = 3'd0;
      pend_valid_d = 1'b0;
    end

    if (cmd_i.advance) begin
      if (it_clr_drop) begin
        drop_d = 1'b0;
      end
      if (it_set_drop) begin
        drop_d = 1'b1;
      end
      for (int k = 0; k < HeldDepth; k++) begin
        src_idx = 3'(k) + it_consume;
        if (src_idx < 3'(HeldDepth)) begin
          held_d[2'(k)] = held_q[src_idx[1:0]];
        end
      end
      cnt_d = (it_consume >= cnt_q) ? 3'd0 : cnt_q - it_consume;
    end

    if (cmd_i.trunc) begin
      cnt_d = 3'd0;
    end

    if (produce) begin
      if (pend_valid_q) begin
        out_valid_d    = 1'b1;
        out_char_d     = pend_char_q;
        out_present_d  = 1'b1;
        out_run_end_d  = 1'b0;
        out_text_end_d = 1'b0;
      end
      pend_valid_d = 1'b1;
      pend_char_d  = prod_char;
      nres_d       = nres_q + 3'd1;
    end

    if (cmd_i.finish) begin
      if (pend_valid_q) begin
        out_valid_d    = 1'b1;
        out_char_d     = pend_char_q;
        out_present_d  = 1'b1;
        out_run_end_d  = 1'b1;
        out_text_end_d = fin_q;
      end else if (fin_q) begin
        out_valid_d    = 1'b1;
        out_char_d     = 8'd0;
        out_present_d  = 1'b0;
        out_run_end_d  = 1'b1;
        out_text_end_d = 1'b1;
      end
      pend_valid_d = 1'b0;
      if (fin_q) begin
        cnt_d  = 3'd0;
        drop_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q        <= 3'd0;
      drop_q       <= 1'b0;
      fin_q        <= 1'b0;
      nres_q       <= 3'd0;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      cnt_q        <= cnt_d;
      drop_q       <= drop_d;
      fin_q        <= fin_d;
      nres_q       <= nres_d;
      pend_valid_q <= pend_valid_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    held_q         <= held_d;
    pend_char_q    <= pend_char_d;
    out_char_q     <= out_char_d;
    out_present_q  <= out_present_d;
    out_run_end_q  <= out_run_end_d;
    out_text_end_q <= out_text_end_d;
  end

  assign out_valid_o    = out_valid_q;
  assign latin_char_o   = out_char_q;
  assign char_present_o = out_present_q;
  assign run_end_o      = out_run_end_q;
  assign text_end_o     = out_text_end_q;

endmodule

`default_nettype wire

### rtl/u2l_ctrl.sv
// ----------------------------------------------------------------------------
// u2l_ctrl : sequencing controller
// Takes a request, runs decode passes until the held bytes stall or empty,
// handles truncation at end of text and releases the closing result.
// ----------------------------------------------------------------------------
`default_nettype none

module u2l_ctrl (
  input  wire                     clk_i,
  input  wire                     rst_ni,
  input  wire                     in_valid_i,
  output logic                    in_ready_o,
  input  wire u2l_pkg::u2l_stat_t stat_i,
  output u2l_pkg::u2l_cmd_t       cmd_o
);
  import u2l_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EVAL,
    S_TRUNC,
    S_FINISH
  } state_e;

  state_e state_q, state_d;
  logic   ready_q;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i && ready_q) begin
          cmd_o.load = 1'b1;
          state_d    = S_EVAL;
        end
      end
      S_EVAL: begin
        if (stat_i.done) begin
          state_d = (stat_i.fin && stat_i.held_any) ? S_TRUNC : S_FINISH;
        end else if (!(stat_i.emit && stat_i.cap_ok && stat_i.blocked)) begin
          cmd_o.advance = 1'b1;
        end
      end
      S_TRUNC: begin
        if (!(stat_i.cap_ok && stat_i.blocked)) begin
          cmd_o.trunc = 1'b1;
          state_d     = S_FINISH;
        end
      end
      S_FINISH: begin
        if (!((stat_i.pend_valid || stat_i.fin) && !stat_i.out_free)) begin
          cmd_o.finish = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      ready_q <= 1'b1;
    end else begin
      state_q <= state_d;
      ready_q <= (state_d == S_IDLE);
    end
  end

  assign in_ready_o = ready_q;

endmodule

`default_nettype wire

### rtl/utf8_to_latin1_transcoder.sv
// ----------------------------------------------------------------------------
// utf8_to_latin1_transcoder : UTF-8 to Latin-1 byte stream converter
// Flow: a request is loaded, decoded one pass per cycle through the shared head
//   decoder while no output stall holds it, a sequence cut off at end of text is
//   substituted, and the closing result is released. A new request is taken
//   only after the previous one has finished.
// Reset: asynchronous, active low; clears held count, CR state and output.
// ----------------------------------------------------------------------------
`default_nettype none

module utf8_to_latin1_transcoder (
  input  wire        clk_i,
  input  wire        rst_ni,
  input  wire        in_valid_i,
  output logic       in_ready_o,
  input  wire [7:0]  text_byte_i,
  input  wire        final_byte_i,
  output logic       out_valid_o,
  input  wire        out_ready_i,
  output logic [7:0] latin_char_o,
  output logic       char_present_o,
  output logic       run_end_o,
  output logic       text_end_o
);
  import u2l_pkg::*;

  u2l_cmd_t  cmd;
  u2l_stat_t stat;

  u2l_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  u2l_datapath u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .stat_o         (stat),
    .text_byte_i    (text_byte_i),
    .final_byte_i   (final_byte_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .latin_char_o   (latin_char_o),
    .char_present_o (char_present_o),
    .run_end_o      (run_end_o),
    .text_end_o     (text_end_o)
  );

endmodule

`default_nettype wire

### verif/tb_utf8_to_latin1_transcoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_utf8_to_latin1_transcoder : self-checking bench for the UTF-8 to Latin-1
// transcoder
// Directed byte runs cover the lead byte classes, overlong forms, code points
// above Latin-1, broken and truncated sequences and CR/CRLF folding. They are
// followed by random texts made mostly of well-formed characters with some
// noise mixed in. A scoreboard decodes each accepted request itself and checks
// every result field in order, under varying source gaps, sink stalls and one
// long sink hold-off.
// ----------------------------------------------------------------------------

import u2l_pkg::*;

typedef struct packed {
  logic [7:0] latin_char;
  logic       char_present;
  logic       run_end;
  logic       text_end;
} latin_res_t;

class latin1_scoreboard;
  latin_res_t latin_q[$];
  latin_res_t step_q[$];
  logic [7:0] held[HeldDepth];
  int unsigned held_cnt = 0;
  bit skip_lf = 1'b0;
  int unsigned mismatches = 0;

  task flag_mismatch(string msg);
    $display("%0t mismatch: %s", $time, msg);
    mismatches++;
  endtask

  function void push_char(logic [7:0] ch);
    if (step_q.size() < MaxResults) begin
      step_q.insert(step_q.size(), latin_res_t'{ch, 1'b1, 1'b0, 1'b0});
    end
  endfunction

  function void drop_held(int unsigned n);
    if (n >= held_cnt) begin
      held_cnt = 0;
      return;
    end
    for (int unsigned k = 0; k + n < held_cnt; k++) begin
      held[k] = held[k + n];
    end
    held_cnt = held_cnt - n;
  endfunction

  // Decode one accepted request and queue the characters it releases.
  function void note_byte(logic [7:0] b, bit fin);
    logic [7:0]  c;
    logic [20:0] cp;
    int unsigned seq_len;
    bit          ok;
    latin_res_t  tail;
    step_q.delete();
    if (held_cnt > 3) held_cnt = 3;
    held[held_cnt] = b;
    held_cnt++;
    while (held_cnt > 0) begin
      c = held[0];
      ok = 1'b1;
      if (skip_lf) begin
        skip_lf = 1'b0;
        if (c == LineFeed) begin
          drop_held(1);
          continue;
        end
      end
      if (c < 8'h80) begin
        cp = 21'(c);
        seq_len = 1;
      end else if ((c & Lead2Mask) == Lead2Pat) begin
        cp = 21'(c & ~Lead2Mask);
        seq_len = 2;
      end else if ((c & Lead3Mask) == Lead3Pat) begin
        cp = 21'(c & ~Lead3Mask);
        seq_len = 3;
      end else if ((c & Lead4Mask) == Lead4Pat) begin
        cp = 21'(c & ~Lead4Mask);
        seq_len = 4;
      end else begin
        push_char(SubstChar);
        drop_held(1);
        continue;
      end
      if (held_cnt < seq_len) break;
      for (int unsigned k = 1; k < seq_len; k++) begin
        if ((held[k] & ContMask) != ContPat) begin
          ok = 1'b0;
          break;
        end
        cp = (cp << 6) | 21'(held[k][5:0]);
      end
      if (!ok) begin
        push_char(SubstChar);
        drop_held(1);
        continue;
      end
      drop_held(seq_len);
      if (cp == 21'(CarriageRet)) begin
        push_char(LineFeed);
        skip_lf = 1'b1;
      end else if (cp <= 21'h0000FF) begin
        push_char(cp[7:0]);
      end else begin
        push_char(SubstChar);
      end
    end
    if (fin) begin
      if (held_cnt > 0) push_char(SubstChar);
      held_cnt = 0;
      skip_lf = 1'b0;
      if (step_q.size() == 0) begin
        step_q.insert(0, latin_res_t'{8'h00, 1'b0, 1'b0, 1'b0});
      end
      tail = step_q.pop_back();
      tail.run_end = 1'b1;
      tail.text_end = 1'b1;
      step_q.insert(step_q.size(), tail);
    end else if (step_q.size() > 0) begin
      tail = step_q.pop_back();
      tail.run_end = 1'b1;
      step_q.insert(step_q.size(), tail);
    end
    foreach (step_q[i]) latin_q.insert(latin_q.size(), step_q[i]);
  endfunction

  task check_char(logic [7:0] ch, logic present, logic run_end, logic text_end);
    latin_res_t want;
    if (latin_q.size() == 0) begin
      flag_mismatch($sformatf("unexpected result char %02h present %b", ch, present));
      return;
    end
    want = latin_q.pop_front();
    if (ch !== want.latin_char) begin
      flag_mismatch($sformatf("latin_char %02h, want %02h", ch, want.latin_char));
    end
    if (present !== want.char_present) begin
      flag_mismatch($sformatf("char_present %b, want %b", present, want.char_present));
    end
    if (run_end !== want.run_end) begin
      flag_mismatch($sformatf("run_end %b, want %b (char %02h)", run_end, want.run_end,
                              want.latin_char));
    end
    if (text_end !== want.text_end) begin
      flag_mismatch($sformatf("text_end %b, want %b (char %02h)", text_end, want.text_end,
                              want.latin_char));
    end
  endtask
endclass

module tb_utf8_to_latin1_transcoder;

  localparam int unsigned PhaseLen    = 90;
  localparam int unsigned TotalItems  = 230;
  localparam int unsigned HoldCycles  = 300;
  localparam int unsigned StallLimit  = 2000;
  localparam int unsigned DrainCycles = 20;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       in_valid_i = 1'b0;
  logic       in_ready_o;
  logic [7:0] text_byte_i = 8'h00;
  logic       final_byte_i = 1'b0;
  logic       out_valid_o;
  logic       out_ready_i = 1'b0;
  logic [7:0] latin_char_o;
  logic       char_present_o;
  logic       run_end_o;
  logic       text_end_o;

  int unsigned src_idle_pct = 20;
  int unsigned sink_stall_pct = 76;
  bit          hold_req = 1'b0;
  int unsigned sent_cnt = 0;
  int unsigned quiet_cycles = 0;
  logic [7:0]  text_q[$];

  latin1_scoreboard sb = new();

  utf8_to_latin1_transcoder i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .text_byte_i    (text_byte_i),
    .final_byte_i   (final_byte_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .latin_char_o   (latin_char_o),
    .char_present_o (char_present_o),
    .run_end_o      (run_end_o),
    .text_end_o     (text_end_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Handshakes are sampled as they stood just before the edge.
  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && in_ready_o) begin
      sb.note_byte(text_byte_i, final_byte_i);
    end
    if (rst_ni && out_valid_o && out_ready_i) begin
      sb.check_char(latin_char_o, char_present_o, run_end_o, text_end_o);
    end
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= StallLimit) begin
      $display("utf8_to_latin1_transcoder regression: fail");
      $finish;
    end
  end

  initial begin
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        out_ready_i <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
      end
      out_ready_i <= ($urandom_range(99) >= sink_stall_pct);
    end
  end

  function void add_byte(logic [7:0] b);
    text_q.insert(text_q.size(), b);
  endfunction

  task offer_byte(logic [7:0] b, bit fin);
    if (sent_cnt == PhaseLen) begin
      src_idle_pct = 76;
      sink_stall_pct = 20;
    end else if (sent_cnt == 2 * PhaseLen) begin
      src_idle_pct = 0;
      sink_stall_pct = 0;
      hold_req = 1'b1;
    end
    if ($urandom_range(99) < src_idle_pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < src_idle_pct);
    end
    in_valid_i   <= 1'b1;
    text_byte_i  <= b;
    final_byte_i <= fin;
    do @(posedge clk_i); while (!in_ready_o);
    sent_cnt++;
  endtask

  initial begin
    logic [8:0]  directed_q[$];
    logic [31:0] rnd;
    int unsigned units;
    // {final, byte}
    directed_q = '{9'h000, 9'h07F,
                   9'h0C3, 9'h0A9,
                   9'h0C0, 9'h080,
                   9'h0E2, 9'h082, 9'h0AC,
                   9'h0F0, 9'h09F, 9'h098, 9'h080,
                   9'h080, 9'h0FF, 9'h0F8,
                   9'h0C3, 9'h041,
                   9'h0F0, 9'h080, 9'h080, 9'h041,
                   9'h0C0, 9'h08D, 9'h00A,
                   9'h00D, 9'h10A,
                   9'h0E2, 9'h182};
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_q[i]) offer_byte(directed_q[i][7:0], directed_q[i][8]);

    while (sent_cnt < TotalItems) begin
      text_q.delete();
      units = $urandom_range(1, 6);
      repeat (units) begin
        rnd = $urandom;
        case ($urandom_range(0, 9))
          0, 1, 2: add_byte({1'b0, rnd[6:0]});
          3: begin
            add_byte(CarriageRet);
            if (rnd[8]) add_byte(LineFeed);
          end
          4: begin
            add_byte({3'b110, rnd[4:0]});
            add_byte({2'b10, rnd[13:8]});
          end
          5: begin
            add_byte({4'b1110, rnd[3:0]});
            add_byte({2'b10, rnd[13:8]});
            add_byte({2'b10, rnd[21:16]});
          end
          6: begin
            add_byte({5'b11110, rnd[2:0]});
            add_byte({2'b10, rnd[13:8]});
            add_byte({2'b10, rnd[21:16]});
            add_byte({2'b10, rnd[29:24]});
          end
          7: begin
            // sequence left short
            case (rnd[31:30])
              2'd0: add_byte({3'b110, rnd[4:0]});
              2'd1: add_byte({4'b1110, rnd[3:0]});
              2'd2: begin
                add_byte({4'b1110, rnd[3:0]});
                add_byte({2'b10, rnd[13:8]});
              end
              default: begin
                add_byte({5'b11110, rnd[2:0]});
                add_byte({2'b10, rnd[13:8]});
                add_byte({2'b10, rnd[21:16]});
              end
            endcase
          end
          8: add_byte(rnd[7:0]);
          default: begin
            add_byte({4'b1110, rnd[3:0]});
            add_byte({2'b10, rnd[13:8]});
            add_byte(rnd[23:16]);
          end
        endcase
      end
      foreach (text_q[i]) offer_byte(text_q[i], i == text_q.size() - 1);
    end
    in_valid_i <= 1'b0;
    @(posedge clk_i);

    while (sb.latin_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (sb.mismatches == 0 && sb.latin_q.size() == 0) begin
      $display("utf8_to_latin1_transcoder regression: pass");
    end else begin
      $display("utf8_to_latin1_transcoder regression: fail");
    end
    $finish;
  end

endmodule

### sim.f
rtl/u2l_pkg.sv
rtl/u2l_datapath.sv
rtl/u2l_ctrl.sv
rtl/utf8_to_latin1_transcoder.sv
verif/tb_utf8_to_latin1_transcoder.sv
